/* design/stp_pkg.sv */
package stp_pkg;

   // number of timer slots; slot, count and result widths are sized for it
   localparam int POOL_SIZE = 16;

   typedef enum logic [2:0] {
      OP_NEW    = 3'd0,
      OP_START  = 3'd1,
      OP_STOP   = 3'd2,
      OP_DELETE = 3'd3,
      OP_TICK   = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      KIND_ALLOC = 2'd0,
      KIND_ACK   = 2'd1,
      KIND_FIRED = 2'd2,
      KIND_DONE  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NO_FREE = 2'd1,
      ST_DUP     = 2'd2,
      ST_NOALLOC = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_TICK_RD,
      S_TICK_EV,
      S_EMIT,
      S_DONE
   } state_type;

   // one command as held in the command queue
   typedef struct packed {
      op_type      op;
      logic [3:0]  slot;
      logic [15:0] actor;
      logic [15:0] msg;
      logic [31:0] delay;
      logic [31:0] elapsed;
   } cmd_type;

   // one result item
   typedef struct packed {
      kind_type    kind;
      status_type  status;
      logic [3:0]  slot;
      logic [15:0] actor;
      logic [15:0] msg;
      logic [4:0]  in_use;
      logic        last;
   } rsp_type;

endpackage

/* design/stp_front.sv */
// Front end: two-entry command queue between request port and executor
module stp_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  stp_pkg::cmd_type cmd_in,
   output logic             cmd_valid,
   input  logic             cmd_take,
   output stp_pkg::cmd_type cmd_out
);
   import stp_pkg::*;

   cmd_type    buf_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full      = cnt_ff == 2'd2;
   assign cmd_valid = cnt_ff != 2'd0;
   assign cmd_out   = buf_ff[rp_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_take && cmd_valid;

   // pointer and count update
   always_comb begin
      wp_in  = wp_ff ^ do_push;
      rp_in  = rp_ff ^ do_pop;
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         buf_ff[wp_ff] <= cmd_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("command queue count out of range");
   assert property (@(posedge clock) disable iff (reset)
      (cmd_valid && !cmd_take && !do_push) |=> $stable(cnt_ff))
      else $error("command queue lost an entry");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0) |-> !do_pop)
      else $error("pop from empty command queue");

endmodule

/* design/stp_exec.sv */
// Back end: executes one command at a time, stepping through its lists entry by entry
module stp_exec (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_take,
   input  stp_pkg::cmd_type cmd,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output stp_pkg::rsp_type rsp
);
   import stp_pkg::*;

   localparam int IW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
   localparam int CW = $clog2(POOL_SIZE + 1);

   state_type state_ff, state_in;

   // small lists in flip-flops; the free queue shifts one entry per cycle, the armed list closes its gap at once
   logic [3:0]  freeq_ff [POOL_SIZE];
   logic [3:0]  armq_ff  [POOL_SIZE];
   logic [CW-1:0] fcnt_ff, acnt_ff;
   logic [POOL_SIZE-1:0] alloc_ff, armed_ff;
   // per-slot payload memories
   logic [31:0] rem_mem   [POOL_SIZE];
   logic [15:0] actor_mem [POOL_SIZE];
   logic [15:0] msg_mem   [POOL_SIZE];

   cmd_type     cur_ff;
   logic [CW-1:0] idx_ff;
   logic [4:0]  nfired_ff;
   logic [3:0]  tslot_ff;
   logic [31:0] rem_rd_ff;
   logic [15:0] act_rd_ff, msg_rd_ff;
   logic        shift_free_ff;  // shift free queue (new) vs armed list
   logic        release_ff;     // after armed shift, release slot (delete)

   rsp_type     out_ff;
   logic        out_v_ff;

   logic        slot_ok;
   logic [IW-1:0] sidx, tidx;
   logic [CW-1:0] in_use_now;
   logic [31:0] rem_new;
   rsp_type     scan_rsp;

   assign slot_ok    = {4'd0, cur_ff.slot} < 8'(POOL_SIZE);
   assign sidx       = IW'(cur_ff.slot);
   assign tidx       = IW'(tslot_ff);
   assign in_use_now = CW'(POOL_SIZE) - fcnt_ff;
   assign rem_new    = (cur_ff.elapsed >= rem_rd_ff) ? 32'd0
                                                     : rem_rd_ff - cur_ff.elapsed;
   assign cmd_take   = (state_ff == S_IDLE) && !out_v_ff;
   assign rsp_valid  = out_v_ff;
   assign rsp        = out_ff;

   // next state, and the single result of a non-tick command
   always_comb begin
      state_in = state_ff;
      scan_rsp = '{kind: KIND_ACK, status: ST_OK, slot: 4'd0, actor: 16'd0,
                   msg: 16'd0, in_use: 5'(in_use_now), last: 1'b1};
      case (cur_ff.op) inside
         OP_NEW: begin
            scan_rsp.kind = KIND_ALLOC;
            if (fcnt_ff == '0) begin
               scan_rsp.status = ST_NO_FREE;
            end else begin
               scan_rsp.slot   = freeq_ff[0];
               scan_rsp.in_use = 5'(in_use_now + 1'b1);
            end
         end
         OP_START: begin
            if (!slot_ok || !alloc_ff[sidx]) begin
               scan_rsp.status = ST_NOALLOC;
            end else if (armed_ff[sidx]) begin
               scan_rsp.status = ST_DUP;
            end
         end
         OP_STOP, OP_DELETE: begin
            if (!slot_ok) begin
               scan_rsp.status = ST_NOALLOC;
            end else if (!alloc_ff[sidx]) begin
               scan_rsp.status = (cur_ff.op == OP_STOP) ? ST_NOALLOC : ST_DUP;
            end else if (cur_ff.op == OP_DELETE) begin
               scan_rsp.in_use = 5'(in_use_now - 1'b1);
            end
         end
         default: ;
      endcase
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid && !out_v_ff) state_in = S_SCAN;
         end
         S_SCAN: begin
            state_in = S_DONE;
            case (cur_ff.op) inside
               OP_NEW: begin
                  if (fcnt_ff != '0) state_in = S_SHIFT;
               end
               OP_STOP, OP_DELETE: begin
                  if (slot_ok && alloc_ff[sidx]) state_in = S_SHIFT;
               end
               OP_TICK: state_in = S_TICK_RD;
               default: ;
            endcase
         end
         S_SHIFT: begin
            if (shift_free_ff) begin
               if (!(idx_ff + 1'b1 < CW'(POOL_SIZE))) state_in = S_DONE;
            end else if (idx_ff >= acnt_ff || armq_ff[IW'(idx_ff)] == tslot_ff) begin
               state_in = S_DONE;
            end
         end
         S_TICK_RD: state_in = (idx_ff >= acnt_ff) ? S_DONE : S_TICK_EV;
         S_TICK_EV: begin
            state_in = (rem_new != 32'd0 || nfired_ff >= 5'd16) ? S_TICK_RD : S_EMIT;
         end
         S_EMIT: begin
            if (!out_v_ff || rsp_ready) state_in = S_TICK_RD;
         end
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // sequencer; response register doubles as output stage
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_v_ff <= 1'b0;
         fcnt_ff  <= CW'(POOL_SIZE);
         acnt_ff  <= '0;
         alloc_ff <= '0;
         armed_ff <= '0;
         for (int i = 0; i < POOL_SIZE; i++) begin
            freeq_ff[i] <= 4'(i);
         end
      end else begin
         state_ff <= state_in;
         if (out_v_ff && rsp_ready) begin
            out_v_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (cmd_valid && !out_v_ff) begin
                  cur_ff    <= cmd;
                  idx_ff    <= '0;
                  nfired_ff <= '0;
               end
            end
            S_SCAN: begin
               // classify and do the single-cycle part of each command
               out_ff <= scan_rsp;
               case (cur_ff.op) inside
                  OP_NEW: begin
                     if (fcnt_ff != '0) begin
                        tslot_ff <= freeq_ff[0];
                        alloc_ff[IW'(freeq_ff[0])] <= 1'b1;
                        rem_mem[IW'(freeq_ff[0])]   <= cur_ff.delay;
                        actor_mem[IW'(freeq_ff[0])] <= cur_ff.actor;
                        msg_mem[IW'(freeq_ff[0])]   <= cur_ff.msg;
                        fcnt_ff  <= fcnt_ff - 1'b1;
                        idx_ff   <= '0;
                        shift_free_ff <= 1'b1;
                     end
                  end
                  OP_START: begin
                     if (slot_ok && alloc_ff[sidx] && !armed_ff[sidx] &&
                         acnt_ff < CW'(POOL_SIZE)) begin
                        armq_ff[IW'(acnt_ff)] <= cur_ff.slot;
                        acnt_ff <= acnt_ff + 1'b1;
                        armed_ff[sidx] <= 1'b1;
                     end
                  end
                  OP_STOP, OP_DELETE: begin
                     if (slot_ok && alloc_ff[sidx]) begin
                        tslot_ff <= cur_ff.slot;
                        idx_ff   <= '0;
                        shift_free_ff <= 1'b0;
                        release_ff <= cur_ff.op == OP_DELETE;
                     end
                  end
                  OP_TICK: begin
                     idx_ff   <= '0;
                  end
                  default: ;
               endcase
            end
            S_SHIFT: begin
               // one list entry per cycle: remove entry, close the gap
               if (shift_free_ff) begin
                  if (idx_ff + 1'b1 < CW'(POOL_SIZE)) begin
                     freeq_ff[IW'(idx_ff)] <= freeq_ff[IW'(idx_ff + 1'b1)];
                     idx_ff <= idx_ff + 1'b1;
                  end
               end else if (idx_ff >= acnt_ff) begin
                  // not armed (or finished): release if deleting
                  if (release_ff) begin
                     freeq_ff[IW'(fcnt_ff)] <= tslot_ff;
                     fcnt_ff  <= fcnt_ff + 1'b1;
                     alloc_ff[tidx] <= 1'b0;
                  end
               end else if (armq_ff[IW'(idx_ff)] == tslot_ff) begin
                  // found: splice out and disarm together
                  for (int i = 0; i < POOL_SIZE - 1; i++) begin
                     if (CW'(i) >= idx_ff) armq_ff[i] <= armq_ff[i + 1];
                  end
                  acnt_ff <= acnt_ff - 1'b1;
                  armed_ff[tidx] <= 1'b0;
                  idx_ff  <= CW'(POOL_SIZE);
                  if (release_ff) begin
                     freeq_ff[IW'(fcnt_ff)] <= tslot_ff;
                     fcnt_ff  <= fcnt_ff + 1'b1;
                     alloc_ff[tidx] <= 1'b0;
                  end
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_TICK_RD: begin
               // read one armed slot's payload, or set up the done result once the armed list is walked
               if (idx_ff >= acnt_ff) begin
                  out_ff <= '{kind: KIND_DONE, status: ST_OK, slot: 4'd0,
                              actor: 16'd0, msg: 16'd0, in_use: 5'(in_use_now),
                              last: 1'b1};
               end else begin
                  tslot_ff  <= armq_ff[IW'(idx_ff)];
                  rem_rd_ff <= rem_mem[IW'(armq_ff[IW'(idx_ff)])];
                  act_rd_ff <= actor_mem[IW'(armq_ff[IW'(idx_ff)])];
                  msg_rd_ff <= msg_mem[IW'(armq_ff[IW'(idx_ff)])];
               end
            end
            S_TICK_EV: begin
               rem_mem[tidx] <= rem_new;
               if (rem_new != 32'd0 || nfired_ff >= 5'd16) begin
                  idx_ff   <= idx_ff + 1'b1;
               end else begin
                  for (int i = 0; i < POOL_SIZE - 1; i++) begin
                     if (CW'(i) >= idx_ff) armq_ff[i] <= armq_ff[i + 1];
                  end
                  acnt_ff <= acnt_ff - 1'b1;
                  freeq_ff[IW'(fcnt_ff)] <= tslot_ff;
                  fcnt_ff <= fcnt_ff + 1'b1;
                  alloc_ff[tidx] <= 1'b0;
                  armed_ff[tidx] <= 1'b0;
                  nfired_ff <= nfired_ff + 1'b1;
                  out_ff <= '{kind: KIND_FIRED, status: ST_OK, slot: tslot_ff,
                              actor: act_rd_ff, msg: msg_rd_ff,
                              in_use: 5'(in_use_now - 1'b1), last: 1'b0};
                  out_v_ff <= 1'b1;
               end
            end
            S_EMIT: ;  // wait for fired result to leave before the next step
            S_DONE: begin
               out_v_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset) acnt_ff <= CW'(POOL_SIZE))
      else $error("armed count overflow");
   assert property (@(posedge clock) disable iff (reset) fcnt_ff <= CW'(POOL_SIZE))
      else $error("free count overflow");
   assert property (@(posedge clock) disable iff (reset)
      $countones(armed_ff) == 32'(acnt_ff))
      else $error("armed flags disagree with armed list");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TICK_EV) |-> out_v_ff == 1'b0 || $past(state_ff) == S_TICK_RD)
      else $error("tick step out of order");

endmodule

/* design/software_timer_pool_top.sv */
// Channel   | Handshake    | Payload
// request   | push / full  | req_operation, req_slot, req_actor_tag, req_message_tag,
//           |              | req_delay_ms, req_elapsed
// response  | empty / pop  | rsp_kind, rsp_status, rsp_result_slot, rsp_fired_actor,
//           |              | rsp_fired_message, rsp_in_use, rsp_last
//
// New, stop and delete walk or shift a list after the scan step, one entry a cycle; start does not.
// Tick walks the armed list, reading and then updating each armed slot, and holds after
// each fired slot until pop takes its result.
// Synchronous active-high reset empties both queues and restores the free list.
// A two-entry command queue keeps requests flowing while the executor stalls on pop.
module software_timer_pool_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [2:0]  req_operation,
   input  logic [3:0]  req_slot,
   input  logic [15:0] req_actor_tag,
   input  logic [15:0] req_message_tag,
   input  logic [31:0] req_delay_ms,
   input  logic [31:0] req_elapsed,
   output logic        empty,
   input  logic        pop,
   output logic [1:0]  rsp_kind,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_result_slot,
   output logic [15:0] rsp_fired_actor,
   output logic [15:0] rsp_fired_message,
   output logic [4:0]  rsp_in_use,
   output logic        rsp_last
);
   import stp_pkg::*;

   cmd_type cmd_in, cmd;
   rsp_type rsp;
   logic    cmd_valid, cmd_take, rsp_valid;

   assign cmd_in = '{op: op_type'(req_operation), slot: req_slot, actor: req_actor_tag,
                     msg: req_message_tag, delay: req_delay_ms, elapsed: req_elapsed};

   stp_front u_front (
      .clock, .reset, .push, .full, .cmd_in,
      .cmd_valid, .cmd_take, .cmd_out(cmd)
   );

   stp_exec u_exec (
      .clock, .reset, .cmd_valid, .cmd_take, .cmd,
      .rsp_valid, .rsp_ready(pop), .rsp
   );

   assign empty             = !rsp_valid;
   assign rsp_kind          = rsp.kind;
   assign rsp_status        = rsp.status;
   assign rsp_result_slot   = rsp.slot;
   assign rsp_fired_actor   = rsp.actor;
   assign rsp_fired_message = rsp.msg;
   assign rsp_in_use        = rsp.in_use;
   assign rsp_last          = rsp.last;

endmodule
